[rtl/core/dtt_pkg.sv]
// Shared types and constants for the deadline timer table.
`timescale 1ns / 1ps
package dtt_pkg;
	localparam int TABLE_ENTRIES = 16;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CLK_W = 48;
	localparam int SEQ_W = 32;
	localparam logic [15:0] TICK_PERIOD_RESET = 16'd500;
	localparam logic [CLK_W-1:0] CLOCK_MAX = {CLK_W{1'b1}};
	localparam logic [0:0] REG_TICK_PERIOD = 1'b0;

	typedef enum logic [1:0] {
		FUNC_SCHEDULE = 2'd0,
		FUNC_CANCEL   = 2'd1,
		FUNC_TICK     = 2'd2,
		FUNC_NONE     = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		KIND_SCHEDULED = 3'd0,
		KIND_FULL      = 3'd1,
		KIND_CANCELLED = 3'd2,
		KIND_NOT_FOUND = 3'd3,
		KIND_FIRED     = 3'd4
	} kind_t;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_EXEC   = 5'b00010,
		ST_TICK   = 5'b00100,
		ST_SCAN   = 5'b01000,
		ST_DECIDE = 5'b10000
	} state_t;

	typedef struct packed {
		logic accept;
		logic exec;
		logic tick;
		logic scan;
		logic decide;
	} cmd_t;

	typedef struct packed {
		logic op_tick;
		logic op_none;
		logic out_free;
		logic scan_last;
		logic dec_stall;
		logic dec_found;
	} status_t;
endpackage

[rtl/core/dtt_if.sv]
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
interface dtt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [7:0]  task_id;
	logic [31:0] offset_ms;
	modport source (output valid, func, task_id, offset_ms, input ready);
	modport sink (input valid, func, task_id, offset_ms, output ready);
endinterface

interface dtt_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [7:0] task_id_res;
	logic       last;
	modport source (output valid, kind, task_id_res, last, input ready);
	modport sink (input valid, kind, task_id_res, last, output ready);
endinterface

[rtl/core/dtt_ctrl.sv]
// Controller state machine sequencing request execution and tick scans.
`timescale 1ns / 1ps
module dtt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  dtt_pkg::status_t  st,
	output dtt_pkg::cmd_t     cmd
);
	dtt_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dtt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		req_ready = 1'b0;
		case (state_q)
			dtt_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				cmd.accept = req_valid;
				if (req_valid) state_d = dtt_pkg::ST_EXEC;
			end
			dtt_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
				if (st.op_tick) state_d = dtt_pkg::ST_TICK;
				else if (st.op_none || st.out_free) state_d = dtt_pkg::ST_IDLE;
			end
			dtt_pkg::ST_TICK: begin
				cmd.tick = 1'b1;
				state_d = dtt_pkg::ST_SCAN;
			end
			dtt_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				if (st.scan_last) state_d = dtt_pkg::ST_DECIDE;
			end
			dtt_pkg::ST_DECIDE: begin
				cmd.decide = 1'b1;
				if (!st.dec_stall) state_d = st.dec_found ? dtt_pkg::ST_SCAN : dtt_pkg::ST_IDLE;
			end
			default: state_d = dtt_pkg::ST_IDLE;
		endcase
	end
endmodule

[rtl/core/dtt_dp.sv]
// Datapath: timer table, clock, configuration register and result register.
`timescale 1ns / 1ps
module dtt_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  dtt_pkg::cmd_t     cmd,
	output dtt_pkg::status_t  st,
	input  logic [1:0]        func,
	input  logic [7:0]        task_id,
	input  logic [31:0]       offset_ms,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [0:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output logic [2:0]        kind,
	output logic [7:0]        task_id_res,
	output logic              last
);
	localparam int N = dtt_pkg::TABLE_ENTRIES;
	localparam int IW = dtt_pkg::IDX_W;
	localparam int CW = dtt_pkg::CLK_W;
	localparam int SW = dtt_pkg::SEQ_W;

	logic [15:0]    period_q;
	logic [CW-1:0]  clock_q;
	logic [SW-1:0]  counter_q;
	logic [N-1:0]   valid_q;
	logic [CW-1:0]  dl_q [N];
	logic [7:0]     hd_q [N];
	logic [SW-1:0]  seq_q [N];
	logic [1:0]     op_q;
	logic [7:0]     id_q;
	logic [31:0]    delay_q;
	logic [IW-1:0]  idx_q;
	logic           found_q;
	logic [IW-1:0]  best_q;
	logic [CW-1:0]  best_dl_q;
	logic [SW-1:0]  best_age_q;
	logic           pend_v_q;
	logic [7:0]     pend_id_q;
	logic           rv_q;
	logic [2:0]     kind_q;
	logic [7:0]     id_res_q;
	logic           last_q;

	logic           out_free;
	logic           full;
	logic [IW-1:0]  free_idx;
	logic [N-1:0]   hit;
	logic [CW:0]    dl_sum;
	logic [CW-1:0]  dl_new;
	logic [CW:0]    clk_sum;
	logic [SW-1:0]  age_i;
	logic           cand;
	logic           better;
	logic           exec_do;
	logic           dec_load;

	assign out_free = !rv_q || rsp_ready;
	assign full = &valid_q;

	always_comb begin
		free_idx = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (!valid_q[i]) free_idx = IW'(i);
		end
		for (int i = 0; i < N; i++) begin
			hit[i] = valid_q[i] && (hd_q[i] == id_q);
		end
	end

	assign dl_sum = {1'b0, clock_q} + (CW + 1)'(delay_q);
	assign dl_new = dl_sum[CW] ? dtt_pkg::CLOCK_MAX : dl_sum[CW-1:0];
	assign clk_sum = {1'b0, clock_q} + (CW + 1)'(period_q);

	assign age_i = counter_q - seq_q[idx_q];
	assign cand = valid_q[idx_q] && (dl_q[idx_q] <= clock_q);
	assign better = cand && (!found_q || (dl_q[idx_q] < best_dl_q) ||
		((dl_q[idx_q] == best_dl_q) && (age_i > best_age_q)));

	assign exec_do = cmd.exec && out_free &&
		((op_q == dtt_pkg::FUNC_SCHEDULE) || (op_q == dtt_pkg::FUNC_CANCEL));
	assign dec_load = cmd.decide && pend_v_q && out_free;

	assign st.op_tick = (op_q == dtt_pkg::FUNC_TICK);
	assign st.op_none = (op_q == dtt_pkg::FUNC_NONE);
	assign st.out_free = out_free;
	assign st.scan_last = (idx_q == IW'(N - 1));
	assign st.dec_stall = pend_v_q && !out_free;
	assign st.dec_found = found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= dtt_pkg::TICK_PERIOD_RESET;
		end else if (psel && penable && pwrite && (paddr == dtt_pkg::REG_TICK_PERIOD)) begin
			period_q <= pwdata[15:0];
		end
	end

	assign prdata = (paddr == dtt_pkg::REG_TICK_PERIOD) ? {16'd0, period_q} : 32'd0;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q <= func;
			id_q <= task_id;
			delay_q <= offset_ms;
		end
		if (exec_do && (op_q == dtt_pkg::FUNC_SCHEDULE) && !full) begin
			dl_q[free_idx] <= dl_new;
			hd_q[free_idx] <= id_q;
			seq_q[free_idx] <= counter_q;
		end
		if (cmd.scan && better) begin
			best_q <= idx_q;
			best_dl_q <= dl_q[idx_q];
			best_age_q <= age_i;
		end
		if (cmd.decide && found_q && !st.dec_stall) pend_id_q <= hd_q[best_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q <= '0;
			counter_q <= '0;
			valid_q <= '0;
			idx_q <= '0;
			found_q <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			if (exec_do && (op_q == dtt_pkg::FUNC_SCHEDULE) && !full) begin
				valid_q[free_idx] <= 1'b1;
				counter_q <= counter_q + 1'b1;
			end
			if (exec_do && (op_q == dtt_pkg::FUNC_CANCEL)) valid_q <= valid_q & ~hit;
			if (cmd.tick) begin
				clock_q <= clk_sum[CW] ? dtt_pkg::CLOCK_MAX : clk_sum[CW-1:0];
				idx_q <= '0;
				found_q <= 1'b0;
				pend_v_q <= 1'b0;
			end
			if (cmd.scan) begin
				idx_q <= idx_q + 1'b1;
				if (better) found_q <= 1'b1;
			end
			if (cmd.decide && !st.dec_stall) begin
				idx_q <= '0;
				found_q <= 1'b0;
				pend_v_q <= found_q;
				if (found_q) valid_q[best_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q <= 1'b0;
		end else if (exec_do || dec_load) begin
			rv_q <= 1'b1;
		end else if (rsp_ready) begin
			rv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_do) begin
			id_res_q <= id_q;
			last_q <= 1'b1;
			if (op_q == dtt_pkg::FUNC_SCHEDULE) begin
				kind_q <= full ? dtt_pkg::KIND_FULL : dtt_pkg::KIND_SCHEDULED;
			end else begin
				kind_q <= (|hit) ? dtt_pkg::KIND_CANCELLED : dtt_pkg::KIND_NOT_FOUND;
			end
		end else if (dec_load) begin
			id_res_q <= pend_id_q;
			last_q <= !found_q;
			kind_q <= dtt_pkg::KIND_FIRED;
		end
	end

	assign rsp_valid = rv_q;
	assign kind = kind_q;
	assign task_id_res = id_res_q;
	assign last = last_q;
endmodule

[rtl/core/deadline_timer_table.sv]
// Top level of the deadline timer table.
`timescale 1ns / 1ps
// Schedule and cancel requests pass through the accepting state and one execute
// state, and their single result beat is registered in the execute state; an unused
// request also passes through both states and gives no beat. A tick passes through
// the accepting state, the execute state and a clock update state, then makes one
// scan of the table per fired entry plus one, each scan visiting the TABLE_ENTRIES
// entries one at a time with a single comparator and then a decide step. A result
// beat that is not taken holds the execute and decide steps until it leaves. The
// result register lets the final beat wait while the next request is accepted.
module deadline_timer_table (
	input  logic         clk,
	input  logic         arst_n,
	dtt_req_if.sink      req,
	dtt_rsp_if.source    rsp,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [0:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	dtt_pkg::cmd_t    cmd;
	dtt_pkg::status_t st;

	assign pready = 1'b1;

	dtt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.st        (st),
		.cmd       (cmd)
	);

	dtt_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.func        (req.func),
		.task_id     (req.task_id),
		.offset_ms   (req.offset_ms),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.rsp_valid   (rsp.valid),
		.rsp_ready   (rsp.ready),
		.kind        (rsp.kind),
		.task_id_res (rsp.task_id_res),
		.last        (rsp.last)
	);
endmodule

[rtl/core/dtt_checker.sv]
// Port-level assertions for the deadline timer table and their binding.
`timescale 1ns / 1ps
module dtt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [2:0]  kind,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [0:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid) else $error("result beat dropped");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready) else $error("second request taken");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> kind <= dtt_pkg::KIND_FIRED) else $error("illegal result kind");

	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && (paddr == dtt_pkg::REG_TICK_PERIOD)
		|=> (paddr != dtt_pkg::REG_TICK_PERIOD) || (prdata[15:0] == $past(pwdata[15:0])))
		else $error("tick period readback mismatch");
endmodule

bind deadline_timer_table dtt_checker u_dtt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.kind      (rsp.kind),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.pwdata    (pwdata),
	.prdata    (prdata)
);
